// ===== rtl/lfdc_pkg.sv =====
// lfdc_pkg: constants, packet kind type and byte-wide crc-32 update
// shared by the length framed download checker; no dependencies
package lfdc_pkg;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcPreset = 32'hFFFF_FFFF;
  localparam logic [31:0] CountMax  = 32'hFFFF_FFFF;
  localparam logic [7:0]  CmdSize   = 8'h57;
  localparam logic [7:0]  CmdData   = 8'h58;
  localparam int unsigned PosW      = 3;
  localparam logic [PosW-1:0] PosLimit = PosW'(5);

  typedef enum logic [2:0] {
    KIND_OTHER = 3'b001,
    KIND_SIZE  = 3'b010,
    KIND_DATA  = 3'b100
  } kind_e;

  typedef struct packed {
    logic [31:0] image_crc;
    logic [31:0] image_size;
  } result_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/length_framed_download_crc32_top.sv =====
// length_framed_download_crc32_top: packet byte parser, size capture, crc-32
// and byte counter with a registered result and one skid entry; uses lfdc_pkg
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------------------
//  in      | in_valid_i  | in_stall_o   | data_byte_i, first_of_write_i, last_of_write_i
//  out     | out_valid_o | out_stall_i  | image_crc_o, image_size_o
//
// one request per cycle while in_stall_o is low; the state update and crc fold
// of a byte finish in the cycle it is accepted; results go to the output or skid entry
// in_stall_o rises only when the output register and the skid entry both hold results
// reset clears all download state and presets the crc to all ones
module length_framed_download_crc32_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_write_i,
  input  logic        last_of_write_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] image_crc_o,
  output logic [31:0] image_size_o
);
  import lfdc_pkg::*;

  logic            active_q, active_d;
  logic [31:0]     tgt_q, tgt_d;
  logic [31:0]     pend_q, pend_d;
  logic [31:0]     cnt_q, cnt_d;
  logic [31:0]     crc_q, crc_d;
  kind_e           kind_q, kind_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic            out_vld_q, skid_vld_q;
  result_t         out_q, skid_q, res;
  logic            in_acc, out_acc, res_push;

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;
  assign out_acc    = out_vld_q && !out_stall_i;

  always_comb begin
    active_d = active_q;
    tgt_d    = tgt_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    kind_d   = kind_q;
    pos_d    = pos_q;
    res_push = 1'b0;
    res      = '{image_crc: ~crc_q, image_size: tgt_q};

    if (first_of_write_i) begin
      pos_d  = '0;
      pend_d = '0;
      if (data_byte_i == CmdSize) begin
        kind_d = KIND_SIZE;
      end else if (data_byte_i == CmdData) begin
        kind_d = KIND_DATA;
      end else begin
        kind_d = KIND_OTHER;
      end
    end else if (kind_q == KIND_SIZE) begin
      unique case (pos_q)
        PosW'(1): pend_d[7:0]   = pend_q[7:0]   | data_byte_i;
        PosW'(2): pend_d[15:8]  = pend_q[15:8]  | data_byte_i;
        PosW'(3): pend_d[23:16] = pend_q[23:16] | data_byte_i;
        PosW'(4): pend_d[31:24] = pend_q[31:24] | data_byte_i;
        default: pend_d = pend_q;
      endcase
    end else if (kind_q == KIND_DATA && active_q) begin
      if (cnt_q < tgt_q) begin
        crc_d = crc_fold(crc_q, data_byte_i);
      end
      if (cnt_q != CountMax) begin
        cnt_d = cnt_q + 32'd1;
      end
    end
    if (pos_d < PosLimit) begin
      pos_d = pos_d + PosW'(1);
    end

    if (last_of_write_i) begin
      if (kind_d == KIND_SIZE) begin
        tgt_d    = pend_d;
        cnt_d    = '0;
        crc_d    = CrcPreset;
        active_d = 1'b1;
      end
      if (active_d && cnt_d >= tgt_d) begin
        active_d = 1'b0;
        res_push = 1'b1;
        res      = '{image_crc: ~crc_d, image_size: tgt_d};
      end
      kind_d = KIND_OTHER;
      pos_d  = '0;
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tgt_q    <= '0;
      pend_q   <= '0;
      cnt_q    <= '0;
      crc_q    <= CrcPreset;
      kind_q   <= KIND_OTHER;
      pos_q    <= '0;
    end else if (in_acc) begin
      active_q <= active_d;
      tgt_q    <= tgt_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      kind_q   <= kind_d;
      pos_q    <= pos_d;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_acc) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= in_acc && res_push;
        end
      end else if (in_acc && res_push) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_acc) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (in_acc && res_push) begin
        out_q <= res;
      end
    end else if (in_acc && res_push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign image_crc_o  = out_q.image_crc;
  assign image_size_o = out_q.image_size;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without output result");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLimit)
    else $error("packet position past limit");

  a_idle_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !active_q && !last_of_write_i) |=> $stable(cnt_q))
    else $error("byte count moved while not downloading");

  a_result_ends_download: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_push) |=> (!active_q && out_vld_q))
    else $error("result issued but download still active or output empty");
`endif

endmodule
